// ----- rtl/sql_keyword_string_tagger_top_assert.svh -----
// assertion helpers for the keyword and string tagger
`ifndef SQL_KEYWORD_STRING_TAGGER_TOP_ASSERT_SVH
`define SQL_KEYWORD_STRING_TAGGER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SQLKT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SQLKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sqlkt_pkg.sv -----
`timescale 1ns / 1ps

package sqlkt_pkg;

  localparam int WORD_MAX    = 10;
  localparam int KW_NUM      = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [3:0] wlen_t;
  typedef logic [0:WORD_MAX-1][7:0] word_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_output;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_GAP,
    MODE_WORD,
    MODE_STR,
    MODE_HALT
  } scan_mode_t;

  // output segments of one command, in emission order
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPEN,
    PH_LT,
    PH_WORD,
    PH_GT,
    PH_BYTE,
    PH_CLOSE,
    PH_MARK
  } phase_t;

  // work handed from the front to the back
  typedef struct packed {
    logic       open_s;
    logic       word_en;
    logic       word_kw;
    wlen_t      word_len;
    word_t      word;
    logic       byte_en;
    logic [7:0] lit_byte;
    logic       close_s;
    logic       last;
  } cmd_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;

  localparam logic [0:3][7:0] OPEN_TAG  = {"<S>", 8'h00};
  localparam logic [0:3][7:0] CLOSE_TAG = "</S>";
  localparam wlen_t OPEN_LAST  = 4'd2;
  localparam wlen_t CLOSE_LAST = 4'd3;

  localparam word_t KW_TEXT [KW_NUM] = '{
    {"INSERT", 32'h0}, {"SELECT", 32'h0}, {"UPDATE", 32'h0}, {"DELETE", 32'h0},
    {"CREATE", 32'h0}, {"BUSCA", 40'h0},  {"ACHA", 48'h0},   {"IMPORT", 32'h0},
    {"TEXTO", 40'h0},  {"FROM", 48'h0},   {"WHERE", 40'h0},  {"TABLE", 40'h0},
    {"INTO", 48'h0},   {"VALUES", 32'h0}, {"CORPO", 40'h0},  "LINGUAGENS"
  };

  localparam wlen_t KW_LEN [KW_NUM] = '{
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd4, 4'd6,
    4'd5, 4'd4, 4'd5, 4'd5, 4'd4, 4'd6, 4'd5, 4'd10
  };

  // whole-word match against the keyword table
  function automatic logic is_keyword(word_t w, wlen_t n);
    logic hit;
    logic eq;
    hit = 1'b0;
    for (int k = 0; k < KW_NUM; k++) begin
      eq = (n == KW_LEN[k]);
      for (int i = 0; i < WORD_MAX; i++) begin
        if ((wlen_t'(i) < n) && (w[i] != KW_TEXT[k][i])) eq = 1'b0;
      end
      hit = hit | eq;
    end
    return hit;
  endfunction

  // first segment of a command that follows segment p
  function automatic phase_t next_phase(cmd_t c, phase_t p);
    phase_t r;
    logic   any;
    any = c.open_s | c.word_en | c.byte_en | c.close_s;
    priority if ((p < PH_OPEN) && c.open_s) begin
      r = PH_OPEN;
    end else if ((p < PH_LT) && c.word_en && c.word_kw) begin
      r = PH_LT;
    end else if ((p < PH_WORD) && c.word_en) begin
      r = PH_WORD;
    end else if ((p < PH_GT) && c.word_en && c.word_kw) begin
      r = PH_GT;
    end else if ((p < PH_BYTE) && c.byte_en) begin
      r = PH_BYTE;
    end else if ((p < PH_CLOSE) && c.close_s) begin
      r = PH_CLOSE;
    end else if ((p < PH_MARK) && !any) begin
      r = PH_MARK;
    end else begin
      r = PH_IDLE;
    end
    return r;
  endfunction

endpackage

// ----- rtl/sqlkt_front.sv -----
`timescale 1ns / 1ps

module sqlkt_front
  import sqlkt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output cmd_t     cmd
);

  scan_mode_t mode_r, mode_nxt;
  logic       dq_r, dq_nxt;
  word_t      wbuf_r, wbuf_nxt;
  wlen_t      wlen_r, wlen_nxt;
  logic       tl_r, tl_nxt;

  logic       accept;
  logic [7:0] b;
  logic       blank;
  logic       overflow;
  cmd_t       c;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_data.text_byte;
  assign blank    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);

  // classify the byte, update scan state and build the command
  always_comb begin
    mode_nxt = mode_r;
    dq_nxt   = dq_r;
    wbuf_nxt = wbuf_r;
    wlen_nxt = wlen_r;
    tl_nxt   = tl_r;
    overflow = 1'b0;
    c        = '0;
    c.lit_byte = b;

    unique case (mode_r)
      MODE_GAP: begin
        if (blank) begin
          mode_nxt = MODE_GAP;
        end else if ((b == CH_SQUOTE) || (b == CH_DQUOTE)) begin
          c.open_s = 1'b1;
          dq_nxt   = (b == CH_DQUOTE);
          mode_nxt = MODE_STR;
        end else if (b <= CH_SPACE) begin
          mode_nxt = MODE_HALT;
        end else begin
          wbuf_nxt[0] = b;
          wlen_nxt    = 4'd1;
          tl_nxt      = 1'b0;
          mode_nxt    = MODE_WORD;
        end
      end
      MODE_WORD: begin
        if (b > CH_SPACE) begin
          if (tl_r) begin
            c.byte_en = 1'b1;
          end else if (wlen_r < wlen_t'(WORD_MAX)) begin
            for (int i = 0; i < WORD_MAX; i++) begin
              if (wlen_t'(i) == wlen_r) wbuf_nxt[i] = b;
            end
            wlen_nxt = wlen_r + 4'd1;
          end else begin
            // buffer overflowed: flush it and pass the rest through
            overflow   = 1'b1;
            c.word_en  = 1'b1;
            c.word     = wbuf_r;
            c.word_len = wlen_r;
            c.byte_en  = 1'b1;
            tl_nxt     = 1'b1;
            wlen_nxt   = '0;
          end
        end else begin
          if (!tl_r) begin
            c.word_en  = 1'b1;
            c.word     = wbuf_r;
            c.word_len = wlen_r;
          end
          wlen_nxt = '0;
          tl_nxt   = 1'b0;
          mode_nxt = blank ? MODE_GAP : MODE_HALT;
        end
      end
      MODE_STR: begin
        if (b == (dq_r ? CH_DQUOTE : CH_SQUOTE)) begin
          c.close_s = 1'b1;
          mode_nxt  = MODE_GAP;
        end else begin
          c.byte_en = 1'b1;
        end
      end
      MODE_HALT: begin
        mode_nxt = MODE_HALT;
      end
      default: begin
        mode_nxt = MODE_HALT;
      end
    endcase

    // end of text closes any open word or string, then back to reset
    if (in_data.end_of_text) begin
      if ((mode_nxt == MODE_WORD) && !tl_nxt) begin
        c.word_en  = 1'b1;
        c.word     = wbuf_nxt;
        c.word_len = wlen_nxt;
      end
      if (mode_nxt == MODE_STR) c.close_s = 1'b1;
      c.last   = 1'b1;
      mode_nxt = MODE_GAP;
      dq_nxt   = 1'b0;
      wlen_nxt = '0;
      tl_nxt   = 1'b0;
    end

    c.word_kw = c.word_en && !overflow && is_keyword(c.word, c.word_len);
  end

  assign cmd  = c;
  assign push = accept && (c.open_s || c.word_en || c.byte_en || c.close_s || c.last);

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GAP;
      dq_r   <= 1'b0;
      wlen_r <= '0;
      tl_r   <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      dq_r   <= dq_nxt;
      wlen_r <= wlen_nxt;
      tl_r   <= tl_nxt;
    end
  end

  // word bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      wbuf_r <= wbuf_nxt;
    end
  end

endmodule

// ----- rtl/sqlkt_queue.sv -----
`timescale 1ns / 1ps

module sqlkt_queue
  import sqlkt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem_r[rd_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/sqlkt_back.sv -----
`timescale 1ns / 1ps

module sqlkt_back
  import sqlkt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      head_cmd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  phase_t    phase_r, phase_nxt;
  wlen_t     pos_r, pos_nxt;
  cmd_t      cmd_r, cmd_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic      out_free;
  wlen_t     seg_last;
  logic      seg_end;
  phase_t    np;
  logic      emit;
  logic      load;
  out_item_t item;

  assign out_free = !out_valid_r || !out_stall;

  // walk the segments of the current command, one byte per transfer
  always_comb begin
    unique case (phase_r)
      PH_OPEN:  seg_last = OPEN_LAST;
      PH_CLOSE: seg_last = CLOSE_LAST;
      PH_WORD:  seg_last = cmd_r.word_len - 4'd1;
      default:  seg_last = '0;
    endcase
    seg_end = (pos_r == seg_last);
    np      = next_phase(cmd_r, phase_r);
    emit    = (phase_r != PH_IDLE) && out_free;
    load    = !q_empty && ((phase_r == PH_IDLE) || (emit && seg_end && (np == PH_IDLE)));

    // byte for this step
    item = '0;
    item.byte_valid    = 1'b1;
    item.end_of_output = cmd_r.last && seg_end && (np == PH_IDLE);
    unique case (phase_r)
      PH_OPEN:  item.out_byte = OPEN_TAG[pos_r[1:0]];
      PH_LT:    item.out_byte = CH_LT;
      PH_WORD:  item.out_byte = cmd_r.word[pos_r];
      PH_GT:    item.out_byte = CH_GT;
      PH_BYTE:  item.out_byte = cmd_r.lit_byte;
      PH_CLOSE: item.out_byte = CLOSE_TAG[pos_r[1:0]];
      PH_MARK:  item.byte_valid = 1'b0;
      default:  item.byte_valid = 1'b0;
    endcase

    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    cmd_nxt   = cmd_r;
    if (emit) begin
      if (seg_end) begin
        phase_nxt = np;
        pos_nxt   = '0;
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
    if (load) begin
      cmd_nxt   = head_cmd;
      phase_nxt = next_phase(head_cmd, PH_IDLE);
      pos_nxt   = '0;
    end

    // output register
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
    out_data_nxt  = emit ? item : out_data_r;
  end

  assign pop       = load;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/sql_keyword_string_tagger_top.sv -----
// path: input byte -> command queue -> back end command register -> output register -> out_valid
// throughput: one input byte per cycle while the command queue has room,
//   one result byte per cycle from the back end while out_stall is low; a command that finds
//   the back end idle is loaded into the command register before its first byte goes out
// reset: synchronous active-low rst_n empties the queue and clears scan state
`timescale 1ns / 1ps
`include "sql_keyword_string_tagger_top_assert.svh"

module sql_keyword_string_tagger_top
  import sqlkt_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic fe_push;
  cmd_t fe_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_head;

  // byte classifier and word buffer
  sqlkt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (fe_push),
    .cmd      (fe_cmd)
  );

  // command queue between front and back
  sqlkt_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_push),
    .push_cmd (fe_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (q_head),
    .empty    (q_empty)
  );

  // segment sequencer and output register
  sqlkt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_cmd  (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks
  `SQLKT_ASSERT_NOW(a_no_push_when_full, fe_push, !q_full, "push into a full queue")
  `SQLKT_ASSERT_NEXT(a_end_queued, in_valid && !in_stall && in_data.end_of_text, !q_empty, "end of text left no command")
  `SQLKT_ASSERT_NOW(a_marker_is_final, out_valid && !out_data.byte_valid, out_data.end_of_output, "bare marker not final")

endmodule
